FILE: rtl/udp_receive_filter_unit_assert.svh
// Assertion macros shared by the UDP receive filter RTL.
// Needs nothing else; the files that check their own logic include it.
`ifndef UDP_RECEIVE_FILTER_UNIT_ASSERT_SVH
`define UDP_RECEIVE_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define URF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, switched off while reset is held.
`define URF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: rtl/urf_pkg.sv
// Package for the UDP receive filter: widths, codes, shared types and the
// one's-complement adder. Depends on nothing.
package urf_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PROTO_W     = 8;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned CFG_INDEX_W = 1;
    // Seven 16-bit terms summed without folding need three extra bits.
    localparam int unsigned SUM_W       = WORD_W + 3;

    localparam logic [PROTO_W-1:0] UDP_PROTOCOL     = 8'd17;
    localparam logic [WORD_W-1:0]  UDP_HEADER_BYTES = 16'd8;
    localparam logic [WORD_W-1:0]  ONES_ALL         = 16'hFFFF;
    localparam logic [WORD_W-1:0]  ODD_BYTE_MASK    = 16'hFF00;
    localparam logic [WORD_W-1:0]  MAX_DATA_BYTES   = 16'hFFF7;

    localparam logic [WORD_W-1:0] IDX_SRC_PORT = 16'd0;
    localparam logic [WORD_W-1:0] IDX_DST_PORT = 16'd1;
    localparam logic [WORD_W-1:0] IDX_UDP_LEN  = 16'd2;
    localparam logic [WORD_W-1:0] IDX_CHECKSUM = 16'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_NOT_UDP       = 3'd1,
        ST_TOO_SHORT     = 3'd2,
        ST_OVERRUN       = 3'd3,
        ST_PORT_MISMATCH = 3'd4,
        ST_BAD_CHECKSUM  = 3'd5
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LISTEN_PORT   = 1'b0,
        REG_MAX_USER_SIZE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [WORD_W-1:0] listen_port;
        logic [WORD_W-1:0] max_user_size;
    } t_cfg;

    // Everything known about one datagram once its last word has been summed.
    typedef struct packed {
        logic [WORD_W-1:0]  sum;
        logic [WORD_W-1:0]  src_port;
        logic [WORD_W-1:0]  dst_port;
        logic [WORD_W-1:0]  udp_len;
        logic [WORD_W-1:0]  checksum;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PROTO_W-1:0] protocol;
        logic [WORD_W-1:0]  ip_len;
    } t_dgram;

    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

FILE: rtl/urf_if.sv
// Channel interfaces of the UDP receive filter: payload words in, results
// out and configuration writes. Depends on urf_pkg.
interface urf_in_if;
    logic                          valid;
    logic                          ready;
    logic [urf_pkg::WORD_W-1:0]    payload_word;
    logic                          last_word;
    logic [urf_pkg::ADDR_W-1:0]    source_address;
    logic [urf_pkg::ADDR_W-1:0]    destination_address;
    logic [urf_pkg::PROTO_W-1:0]   ip_protocol;
    logic [urf_pkg::WORD_W-1:0]    ip_payload_length;

    modport source (output valid, payload_word, last_word, source_address,
                    destination_address, ip_protocol, ip_payload_length,
                    input ready);
    modport sink   (input valid, payload_word, last_word, source_address,
                    destination_address, ip_protocol, ip_payload_length,
                    output ready);
endinterface

interface urf_out_if;
    logic                          valid;
    logic                          ready;
    logic [urf_pkg::STATUS_W-1:0]  status;
    logic [urf_pkg::ADDR_W-1:0]    sender_address;
    logic [urf_pkg::WORD_W-1:0]    sender_port;
    logic [urf_pkg::WORD_W-1:0]    target_port;
    logic [urf_pkg::WORD_W-1:0]    user_length;

    modport source (output valid, status, sender_address, sender_port, target_port,
                    user_length, input ready);
    modport sink   (input valid, status, sender_address, sender_port, target_port,
                    user_length, output ready);
endinterface

interface urf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [urf_pkg::CFG_INDEX_W-1:0]   index;
    logic [urf_pkg::WORD_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/urf_cfg_regs.sv
// Configuration registers of the UDP receive filter: listen port and user
// buffer size. Depends on urf_pkg and urf_cfg_if.
module urf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    urf_cfg_if.sink       i_cfg,
    output urf_pkg::t_cfg o_cfg
);
    import urf_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_port   <= '0;
            r_cfg.max_user_size <= ONES_ALL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_LISTEN_PORT:   r_cfg.listen_port   <= i_cfg.data;
                REG_MAX_USER_SIZE: r_cfg.max_user_size <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/urf_accum.sv
// Input register and per-datagram running state of the UDP receive filter.
// Depends on urf_pkg, urf_in_if and the assertion macro header.
`include "udp_receive_filter_unit_assert.svh"
module urf_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    urf_in_if.sink          i_in,
    output urf_pkg::t_dgram o_dgram,
    output logic            o_dgram_valid,
    input  logic            i_dgram_ready
);
    import urf_pkg::*;

    // Input register.
    logic               r_a_valid;
    logic [WORD_W-1:0]  r_a_word;
    logic               r_a_last;
    logic [ADDR_W-1:0]  r_a_src;
    logic [ADDR_W-1:0]  r_a_dst;
    logic [PROTO_W-1:0] r_a_proto;
    logic [WORD_W-1:0]  r_a_iplen;

    // Running state of the datagram in flight.
    logic [WORD_W-1:0]  r_sum, n_sum;
    logic [WORD_W-1:0]  r_word_index, n_word_index;
    logic [WORD_W-1:0]  r_udp_len, n_udp_len;
    logic [WORD_W-1:0]  r_src_port, n_src_port;
    logic [WORD_W-1:0]  r_dst_port, n_dst_port;
    logic [WORD_W-1:0]  r_checksum, n_checksum;

    // Captured datagram, waiting for the checker.
    logic   r_d_valid;
    t_dgram r_dgram;

    logic              a_fire;
    logic              d_ready;
    logic              add_en;
    logic [WORD_W-1:0] addend;
    logic [WORD_W:0]   byte_pos;

    assign d_ready       = !r_d_valid || i_dgram_ready;
    // A last word may only leave when the datagram register is free.
    assign a_fire        = r_a_valid && (!r_a_last || d_ready);
    assign i_in.ready    = !r_a_valid || a_fire;
    assign o_dgram       = r_dgram;
    assign o_dgram_valid = r_d_valid;

    always_comb begin
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        n_udp_len  = r_udp_len;
        n_checksum = r_checksum;
        add_en     = 1'b0;
        addend     = r_a_word;
        byte_pos   = {r_word_index, 1'b0};
        case (r_word_index)
            IDX_SRC_PORT: begin
                n_src_port = r_a_word;
                add_en     = 1'b1;
            end
            IDX_DST_PORT: begin
                n_dst_port = r_a_word;
                add_en     = 1'b1;
            end
            IDX_UDP_LEN: begin
                n_udp_len = r_a_word;
                add_en    = 1'b1;
            end
            IDX_CHECKSUM: begin
                n_checksum = r_a_word;
            end
            default: begin
                // Data words beyond the UDP length are ignored; an odd
                // final byte is padded with zero.
                if (byte_pos < {1'b0, r_udp_len}) begin
                    add_en = 1'b1;
                    if (byte_pos + 17'd1 == {1'b0, r_udp_len}) begin
                        addend = r_a_word & ODD_BYTE_MASK;
                    end
                end
            end
        endcase
        n_sum        = add_en ? oc_add(r_sum, addend) : r_sum;
        n_word_index = (r_word_index != ONES_ALL) ? r_word_index + 16'd1 : r_word_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_sum        <= '0;
            r_word_index <= '0;
            r_udp_len    <= '0;
            r_src_port   <= '0;
            r_dst_port   <= '0;
            r_checksum   <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end

            if (a_fire && r_a_last) begin
                r_sum        <= '0;
                r_word_index <= '0;
                r_udp_len    <= '0;
                r_src_port   <= '0;
                r_dst_port   <= '0;
                r_checksum   <= '0;
            end else if (a_fire) begin
                r_sum        <= n_sum;
                r_word_index <= n_word_index;
                r_udp_len    <= n_udp_len;
                r_src_port   <= n_src_port;
                r_dst_port   <= n_dst_port;
                r_checksum   <= n_checksum;
            end

            if (a_fire && r_a_last) begin
                r_d_valid <= 1'b1;
            end else if (i_dgram_ready) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_word  <= i_in.payload_word;
            r_a_last  <= i_in.last_word;
            r_a_src   <= i_in.source_address;
            r_a_dst   <= i_in.destination_address;
            r_a_proto <= i_in.ip_protocol;
            r_a_iplen <= i_in.ip_payload_length;
        end
        if (a_fire && r_a_last) begin
            r_dgram.sum      <= n_sum;
            r_dgram.src_port <= n_src_port;
            r_dgram.dst_port <= n_dst_port;
            r_dgram.udp_len  <= n_udp_len;
            r_dgram.checksum <= n_checksum;
            r_dgram.src_addr <= r_a_src;
            r_dgram.dst_addr <= r_a_dst;
            r_dgram.protocol <= r_a_proto;
            r_dgram.ip_len   <= r_a_iplen;
        end
    end

    `URF_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, a_fire && r_a_last, (r_word_index == 16'd0) && (r_sum == 16'd0))
    `URF_ASSERT_NXT(a_index_saturates, i_clk, i_rst_n, a_fire && !r_a_last && (r_word_index == ONES_ALL), r_word_index == ONES_ALL)
    `URF_ASSERT_NXT(a_last_captured, i_clk, i_rst_n, a_fire && r_a_last, r_d_valid)

endmodule

FILE: rtl/urf_verify.sv
// Datagram checks, checksum fold and result register of the UDP receive
// filter. Depends on urf_pkg, urf_out_if and the assertion macro header.
`include "udp_receive_filter_unit_assert.svh"
module urf_verify (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  urf_pkg::t_cfg   i_cfg,
    input  urf_pkg::t_dgram i_dgram,
    input  logic            i_dgram_valid,
    output logic            o_dgram_ready,
    urf_out_if.source       o_out
);
    import urf_pkg::*;

    // Check stage: header checks done, checksum still unfolded.
    logic              r_c_valid;
    logic [SUM_W-1:0]  r_c_total;
    t_status           r_c_pre_status;
    logic              r_c_chk_en;
    logic [WORD_W-1:0] r_c_expect;
    logic [WORD_W-1:0] r_c_ulen;
    logic [ADDR_W-1:0] r_c_src;
    logic [WORD_W-1:0] r_c_src_port;
    logic [WORD_W-1:0] r_c_dst_port;

    // Result register.
    logic              r_o_valid;
    t_status           r_o_status;
    logic [ADDR_W-1:0] r_o_src;
    logic [WORD_W-1:0] r_o_src_port;
    logic [WORD_W-1:0] r_o_dst_port;
    logic [WORD_W-1:0] r_o_user_length;

    logic              out_ready;
    logic              c_adv;
    logic              b_fire;
    logic [SUM_W-1:0]  total;
    t_status           pre_status;
    logic [WORD_W-1:0] data_len;
    logic [WORD_W-1:0] ulen_cand;
    logic [WORD_W:0]   fold1;
    logic [WORD_W-1:0] fold2;
    t_status           fin_status;

    assign out_ready     = !r_o_valid || o_out.ready;
    assign c_adv         = r_c_valid && out_ready;
    assign o_dgram_ready = !r_c_valid || c_adv;
    assign b_fire        = i_dgram_valid && o_dgram_ready;

    // Pseudo-header and running sum added as plain integers; folded later.
    assign total = SUM_W'(i_dgram.sum)
                 + SUM_W'(i_dgram.src_addr[ADDR_W-1:WORD_W])
                 + SUM_W'(i_dgram.src_addr[WORD_W-1:0])
                 + SUM_W'(i_dgram.dst_addr[ADDR_W-1:WORD_W])
                 + SUM_W'(i_dgram.dst_addr[WORD_W-1:0])
                 + SUM_W'(i_dgram.protocol)
                 + SUM_W'(i_dgram.udp_len);

    always_comb begin
        if (i_dgram.protocol != UDP_PROTOCOL) begin
            pre_status = ST_NOT_UDP;
        end else if ((i_dgram.ip_len < UDP_HEADER_BYTES)
                     || (i_dgram.udp_len < UDP_HEADER_BYTES)) begin
            pre_status = ST_TOO_SHORT;
        end else if (i_dgram.udp_len > i_dgram.ip_len) begin
            pre_status = ST_OVERRUN;
        end else if ((i_cfg.listen_port != '0)
                     && (i_cfg.listen_port != i_dgram.dst_port)) begin
            pre_status = ST_PORT_MISMATCH;
        end else begin
            pre_status = ST_OK;
        end
    end

    assign data_len  = i_dgram.udp_len - UDP_HEADER_BYTES;
    assign ulen_cand = (i_cfg.max_user_size < data_len) ? i_cfg.max_user_size : data_len;

    // Two end-around folds bring the sum back to 16 bits.
    assign fold1 = {1'b0, r_c_total[WORD_W-1:0]}
                 + {{(WORD_W-2){1'b0}}, r_c_total[SUM_W-1:WORD_W]};
    assign fold2 = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};

    always_comb begin
        fin_status = r_c_pre_status;
        if ((r_c_pre_status == ST_OK) && r_c_chk_en && (~fold2 != r_c_expect)) begin
            fin_status = ST_BAD_CHECKSUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_fire) begin
                r_c_valid <= 1'b1;
            end else if (c_adv) begin
                r_c_valid <= 1'b0;
            end
            if (c_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_c_total      <= total;
            r_c_pre_status <= pre_status;
            r_c_chk_en     <= (i_dgram.checksum != '0);
            r_c_expect     <= (i_dgram.checksum == ONES_ALL) ? '0 : i_dgram.checksum;
            r_c_ulen       <= ulen_cand;
            r_c_src        <= i_dgram.src_addr;
            r_c_src_port   <= i_dgram.src_port;
            r_c_dst_port   <= i_dgram.dst_port;
        end
        if (c_adv) begin
            r_o_status      <= fin_status;
            r_o_src         <= r_c_src;
            r_o_src_port    <= r_c_src_port;
            r_o_dst_port    <= r_c_dst_port;
            r_o_user_length <= (fin_status == ST_OK) ? r_c_ulen : '0;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.status         = r_o_status;
    assign o_out.sender_address = r_o_src;
    assign o_out.sender_port    = r_o_src_port;
    assign o_out.target_port    = r_o_dst_port;
    assign o_out.user_length    = r_o_user_length;

    `URF_ASSERT_IMP(v_reject_no_length, i_clk, i_rst_n, r_o_valid && (r_o_status != ST_OK), r_o_user_length == 16'd0)
    `URF_ASSERT_IMP(v_ok_length_bound, i_clk, i_rst_n, r_o_valid && (r_o_status == ST_OK), r_o_user_length <= MAX_DATA_BYTES)
    `URF_ASSERT_NXT(v_header_fail_kept, i_clk, i_rst_n, c_adv && (r_c_pre_status != ST_OK), r_o_status == $past(r_c_pre_status))
    `URF_ASSERT_NXT(v_check_stage_holds, i_clk, i_rst_n, r_c_valid && !c_adv, r_c_valid && $stable(r_c_total))

endmodule

FILE: rtl/udp_receive_filter_unit.sv
// UDP receive filter top level: header checks and checksum verification of
// one IP payload stream. Depends on urf_pkg, the interfaces and submodules.
//
// Usage: i_in carries the IP payload as 16-bit big-endian words, one word
// per transaction, with last_word set on the final word; the IP addresses,
// protocol and payload length are taken from the last-word transaction.
// o_out delivers one result transaction per datagram: status, sender
// address and ports, and the user length capped at max_user_size.
// i_cfg writes listen_port (index 0) and max_user_size (index 1); it is
// always ready and should only be used while no datagram is in flight.
// Throughput is one word per clock cycle while the output is not stalled. After
// the transaction of its last word, a result passes the input register, the
// datagram register (running sum), the check stage (pseudo-header sum and
// header checks) and the end-around fold into the result register.
// Reset clears the running datagram state and the pipeline, sets the listen
// port to 0 (any port) and max_user_size to 65535.
// When the receiver stalls, the result register, the check stage and the
// datagram register fill up, and i_in.ready drops once a further last word
// waits in the input register; non-final words keep flowing into the
// running sum until then.
module udp_receive_filter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    urf_in_if.sink    i_in,
    urf_out_if.source o_out,
    urf_cfg_if.sink   i_cfg
);
    import urf_pkg::*;

    t_cfg   cfg;
    t_dgram dgram;
    logic   dgram_valid;
    logic   dgram_ready;

    urf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    urf_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_dgram       (dgram),
        .o_dgram_valid (dgram_valid),
        .i_dgram_ready (dgram_ready)
    );

    urf_verify u_verify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_dgram       (dgram),
        .i_dgram_valid (dgram_valid),
        .o_dgram_ready (dgram_ready),
        .o_out         (o_out)
    );

endmodule

FILE: dv/tb_udp_receive_filter_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for udp_receive_filter_unit: whole datagrams are streamed in
// word by word and every result transaction is checked against a built-in predictor.
// Depends on urf_pkg, the channel interfaces in urf_if.sv and the block itself.
module tb_udp_receive_filter_unit;
    import urf_pkg::*;

    localparam int SETTLE_CYCLES      = 8;
    localparam int QUIET_LIMIT        = 2000;
    localparam int LONG_HOLD          = 400;
    localparam int HOLD_AFTER_RESULTS = 12;
    localparam int WORDS_PER_PHASE    = 200;

    typedef enum {CK_GOOD, CK_ZERO, CK_BAD, CK_RAW, CK_ZERO_SUM} t_csum_kind;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic               last;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [PROTO_W-1:0] proto;
        logic [WORD_W-1:0]  iplen;
    } t_payload_beat;

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] sender_address;
        logic [WORD_W-1:0] sender_port;
        logic [WORD_W-1:0] target_port;
        logic [WORD_W-1:0] user_length;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    urf_in_if  in_if ();
    urf_out_if out_if ();
    urf_cfg_if cfg_if ();

    udp_receive_filter_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_payload_beat words_to_send[$];
    t_verdict      pending_verdicts[$];
    logic [CFG_INDEX_W+WORD_W-1:0] reg_writes_to_send[$];

    // Predictor state: configuration shadow and the datagram being summed.
    logic [WORD_W-1:0] listen_shadow;
    logic [WORD_W-1:0] max_size_shadow;
    logic [WORD_W-1:0] acc_sum;
    logic [WORD_W-1:0] word_idx;
    logic [WORD_W-1:0] udp_len_q;
    logic [WORD_W-1:0] sport_q;
    logic [WORD_W-1:0] dport_q;
    logic [WORD_W-1:0] csum_q;

    t_payload_beat beat_on_bus;
    t_verdict      got_verdict;
    logic [WORD_W-1:0] listen_now;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    int  results_seen;
    int  quiet_cycles;
    int  fail_count;
    int  words_queued;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] fold_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

    function automatic void clear_datagram_state();
        acc_sum   = '0;
        word_idx  = '0;
        udp_len_q = '0;
        sport_q   = '0;
        dport_q   = '0;
        csum_q    = '0;
    endfunction

    // Follows one accepted payload word; a last word yields the verdict for its datagram.
    task automatic absorb_payload_word(input t_payload_beat b);
        t_verdict          v;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] wanted;
        int unsigned       bpos;
        case (word_idx)
            IDX_SRC_PORT: begin
                sport_q = b.word;
                acc_sum = fold_add(acc_sum, b.word);
            end
            IDX_DST_PORT: begin
                dport_q = b.word;
                acc_sum = fold_add(acc_sum, b.word);
            end
            IDX_UDP_LEN: begin
                udp_len_q = b.word;
                acc_sum   = fold_add(acc_sum, b.word);
            end
            IDX_CHECKSUM: csum_q = b.word;
            default: begin
                bpos = 2 * word_idx;
                if (bpos < udp_len_q) begin
                    if (bpos + 1 == udp_len_q)
                        acc_sum = fold_add(acc_sum, b.word & ODD_BYTE_MASK);
                    else
                        acc_sum = fold_add(acc_sum, b.word);
                end
            end
        endcase
        if (word_idx != ONES_ALL)
            word_idx = word_idx + 1'b1;
        if (!b.last)
            return;

        if (b.proto != UDP_PROTOCOL) begin
            v.status = ST_NOT_UDP;
        end else if (b.iplen < UDP_HEADER_BYTES || udp_len_q < UDP_HEADER_BYTES) begin
            v.status = ST_TOO_SHORT;
        end else if (udp_len_q > b.iplen) begin
            v.status = ST_OVERRUN;
        end else if (listen_shadow != '0 && listen_shadow != dport_q) begin
            v.status = ST_PORT_MISMATCH;
        end else begin
            v.status = ST_OK;
            if (csum_q != '0) begin
                s = fold_add(acc_sum, b.src[31:16]);
                s = fold_add(s, b.src[15:0]);
                s = fold_add(s, b.dst[31:16]);
                s = fold_add(s, b.dst[15:0]);
                s = fold_add(s, {8'h00, b.proto});
                s = fold_add(s, udp_len_q);
                // An all-ones checksum field is the transmitted form of zero.
                wanted = (csum_q == ONES_ALL) ? '0 : csum_q;
                if (~s != wanted)
                    v.status = ST_BAD_CHECKSUM;
            end
        end
        v.user_length = '0;
        if (v.status == ST_OK) begin
            v.user_length = udp_len_q - UDP_HEADER_BYTES;
            if (max_size_shadow < v.user_length)
                v.user_length = max_size_shadow;
        end
        v.sender_address = b.src;
        v.sender_port    = sport_q;
        v.target_port    = dport_q;
        pending_verdicts.push_back(v);
        clear_datagram_state();
    endtask

    function automatic void check_field(input string name, input logic [ADDR_W-1:0] expd,
                                        input logic [ADDR_W-1:0] act);
        if (expd !== act) begin
            $error("%s: expected %0h, got %0h", name, expd, act);
            fail_count++;
        end
    endfunction

    // Builds one datagram of nwords words; the checksum field follows the requested kind.
    task automatic queue_dgram(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                               input logic [PROTO_W-1:0] proto, input logic [WORD_W-1:0] iplen,
                               input logic [WORD_W-1:0] sport, input logic [WORD_W-1:0] dport,
                               input logic [WORD_W-1:0] ulen, input t_csum_kind kind,
                               input int nwords);
        logic [WORD_W-1:0] w[$];
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] field;
        t_payload_beat     b;
        t_csum_kind        ck;
        ck = kind;
        if (ck == CK_ZERO_SUM && !(nwords >= 5 && ulen >= 10))
            ck = CK_GOOD;
        w = '{sport, dport, ulen, 16'h0000};
        for (int i = 4; i < nwords; i++)
            w.push_back(WORD_W'($urandom));
        if (ck == CK_ZERO_SUM)
            w[4] = '0;
        acc = '0;
        for (int i = 0; i < nwords; i++) begin
            if (i < 3) begin
                acc = fold_add(acc, w[i]);
            end else if (i > 3 && 2 * i < ulen) begin
                if (2 * i + 1 == ulen)
                    acc = fold_add(acc, w[i] & ODD_BYTE_MASK);
                else
                    acc = fold_add(acc, w[i]);
            end
        end
        acc = fold_add(acc, src[31:16]);
        acc = fold_add(acc, src[15:0]);
        acc = fold_add(acc, dst[31:16]);
        acc = fold_add(acc, dst[15:0]);
        acc = fold_add(acc, {8'h00, proto});
        acc = fold_add(acc, ulen);
        if (ck == CK_ZERO_SUM) begin
            // The first data word brings the sum to all ones, so the checksum is zero.
            w[4] = ~acc;
            acc  = ONES_ALL;
        end
        field = ~acc;
        if (field == '0)
            field = ONES_ALL;
        case (ck)
            CK_ZERO: field = '0;
            CK_BAD:  field = field ^ WORD_W'($urandom_range(1, 65535));
            CK_RAW:  field = WORD_W'($urandom);
            default: ;
        endcase
        w[3] = field;
        for (int i = 0; i < nwords; i++) begin
            b.word  = w[i];
            b.last  = (i == nwords - 1);
            b.src   = src;
            b.dst   = dst;
            b.proto = proto;
            b.iplen = iplen;
            words_to_send.push_back(b);
        end
        words_queued += nwords;
    endtask

    task automatic queue_random_dgram();
        int                 shape;
        int                 pick;
        int                 ulen;
        int                 iplen;
        int                 nwords;
        logic [WORD_W-1:0]  dport;
        logic [PROTO_W-1:0] proto;
        t_csum_kind         ck;
        shape = $urandom_range(0, 99);
        pick  = $urandom_range(0, 99);
        if (listen_now != '0 && $urandom_range(0, 99) < 85)
            dport = listen_now;
        else
            dport = WORD_W'($urandom);
        proto = ($urandom_range(0, 99) < 93) ? UDP_PROTOCOL : PROTO_W'($urandom_range(0, 255));
        if (pick < 72)      ck = CK_GOOD;
        else if (pick < 82) ck = CK_ZERO;
        else if (pick < 92) ck = CK_BAD;
        else if (pick < 96) ck = CK_RAW;
        else                ck = CK_ZERO_SUM;
        if ($urandom_range(0, 99) < 90)
            ulen = 8 + $urandom_range(0, 24);
        else
            ulen = 8 + $urandom_range(25, 64);
        iplen = ulen;
        if ($urandom_range(0, 99) < 15)
            iplen += $urandom_range(1, 5);
        nwords = (iplen + 1) / 2;
        if (shape >= 95) begin
            ulen   = $urandom_range(0, 65535);
            iplen  = $urandom_range(0, 65535);
            proto  = PROTO_W'($urandom_range(0, 255));
            nwords = $urandom_range(1, 8);
            ck     = CK_RAW;
        end else if (shape >= 90) begin
            // Long datagram cut after a few words: exercises the size cap cheaply.
            ulen   = $urandom_range(16'h8000, 16'hFFFF);
            iplen  = $urandom_range(ulen, 65535);
            nwords = $urandom_range(4, 10);
        end else if (shape >= 84) begin
            iplen = $urandom_range(0, ulen - 1);
            nwords = (ulen + 1) / 2;
        end else if (shape >= 78) begin
            ulen   = $urandom_range(0, 7);
            iplen  = $urandom_range(0, 20);
            nwords = $urandom_range(1, 12);
        end else if (shape >= 70) begin
            nwords = $urandom_range(1, nwords);
        end
        queue_dgram($urandom, $urandom, proto, WORD_W'(iplen), WORD_W'($urandom), dport,
                    WORD_W'(ulen), ck, nwords);
    endtask

    // Sampled on the falling edge so that the clocked blocks have settled.
    task automatic wait_until_quiet();
        while (words_to_send.size() != 0 || in_if.valid || pending_verdicts.size() != 0 ||
               reg_writes_to_send.size() != 0 || cfg_if.valid)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_registers(input logic [WORD_W-1:0] listen,
                                 input logic [WORD_W-1:0] max_size);
        reg_writes_to_send.push_back({REG_LISTEN_PORT, listen});
        reg_writes_to_send.push_back({REG_MAX_USER_SIZE, max_size});
        listen_now = listen;
        while (reg_writes_to_send.size() != 0 || cfg_if.valid)
            @(negedge i_clk);
    endtask

    task automatic random_phase(input int budget);
        int start;
        start = words_queued;
        while (words_queued - start < budget)
            queue_random_dgram();
    endtask

    // Sender and configuration writer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            cfg_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                absorb_payload_word(beat_on_bus);
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == REG_LISTEN_PORT)
                    listen_shadow = cfg_if.data;
                else
                    max_size_shadow = cfg_if.data;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    beat_on_bus = words_to_send.pop_front();
                    in_if.valid               <= 1'b1;
                    in_if.payload_word        <= beat_on_bus.word;
                    in_if.last_word           <= beat_on_bus.last;
                    in_if.source_address      <= beat_on_bus.src;
                    in_if.destination_address <= beat_on_bus.dst;
                    in_if.ip_protocol         <= beat_on_bus.proto;
                    in_if.ip_payload_length   <= beat_on_bus.iplen;
                    if (!calm && $urandom_range(0, 99) < 8)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (reg_writes_to_send.size() != 0) begin
                    {cfg_if.index, cfg_if.data} <= reg_writes_to_send.pop_front();
                    cfg_if.valid <= 1'b1;
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction and applies back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (pending_verdicts.size() == 0) begin
                    $error("result transaction arrived with no datagram outstanding");
                    fail_count++;
                end else begin
                    got_verdict = pending_verdicts.pop_front();
                    check_field("status", ADDR_W'(got_verdict.status),
                                ADDR_W'(out_if.status));
                    check_field("sender_address", got_verdict.sender_address,
                                out_if.sender_address);
                    check_field("sender_port", ADDR_W'(got_verdict.sender_port),
                                ADDR_W'(out_if.sender_port));
                    check_field("target_port", ADDR_W'(got_verdict.target_port),
                                ADDR_W'(out_if.target_port));
                    check_field("user_length", ADDR_W'(got_verdict.user_length),
                                ADDR_W'(out_if.user_length));
                end
                // One long hold-off, so that the block fills up and stalls its input.
                if (results_seen == HOLD_AFTER_RESULTS)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 8)
                    recv_gap = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n                   = 1'b0;
        in_if.valid               = 1'b0;
        in_if.payload_word        = '0;
        in_if.last_word           = 1'b0;
        in_if.source_address      = '0;
        in_if.destination_address = '0;
        in_if.ip_protocol         = '0;
        in_if.ip_payload_length   = '0;
        out_if.ready              = 1'b0;
        cfg_if.valid              = 1'b0;
        cfg_if.index              = REG_LISTEN_PORT;
        cfg_if.data               = '0;
        listen_shadow             = '0;
        max_size_shadow           = ONES_ALL;
        listen_now                = '0;
        calm                      = 1'b0;
        fail_count                = 0;
        results_seen              = 0;
        words_queued              = 0;
        clear_datagram_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed datagrams under the reset configuration.
        queue_dgram('1, '1, UDP_PROTOCOL, 16'd8, 16'hFFFF, 16'hFFFF, 16'd8, CK_ZERO, 4);
        queue_dgram('0, '0, UDP_PROTOCOL, 16'd11, 16'h0000, 16'h0000, 16'd11, CK_GOOD, 6);
        queue_dgram($urandom, $urandom, UDP_PROTOCOL, 16'd10, 16'd1000, 16'd2000, 16'd10,
                    CK_ZERO_SUM, 5);
        queue_dgram($urandom, $urandom, 8'hFF, 16'd100, 16'd7, 16'd9, 16'd8, CK_GOOD, 1);
        queue_dgram($urandom, $urandom, UDP_PROTOCOL, 16'd8, 16'd5, 16'd6, 16'd4, CK_GOOD, 4);
        queue_dgram($urandom, $urandom, UDP_PROTOCOL, 16'd10, 16'd5, 16'd6, 16'd20,
                    CK_GOOD, 5);
        queue_dgram($urandom, $urandom, UDP_PROTOCOL, 16'd12, 16'd5, 16'd6, 16'd8, CK_BAD, 6);
        wait_until_quiet();

        set_registers(16'h1234, 16'd0);
        queue_dgram($urandom, $urandom, UDP_PROTOCOL, 16'd8, 16'd1, 16'h4321, 16'd8,
                    CK_GOOD, 4);
        random_phase(WORDS_PER_PHASE);
        wait_until_quiet();

        set_registers(16'hFFFF, 16'hFFFF);
        random_phase(WORDS_PER_PHASE);
        wait_until_quiet();

        set_registers(16'h0000, 16'd10);
        random_phase(WORDS_PER_PHASE);
        wait_until_quiet();

        set_registers(WORD_W'($urandom_range(1, 65535)), WORD_W'($urandom_range(0, 64)));
        random_phase(WORDS_PER_PHASE);
        wait_until_quiet();

        // Final stretch runs at full rate on both sides.
        calm = 1'b1;
        set_registers(16'h0000, 16'hFFFF);
        random_phase(WORDS_PER_PHASE);
        wait_until_quiet();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/urf_pkg.sv
rtl/urf_if.sv
rtl/urf_cfg_regs.sv
rtl/urf_accum.sv
rtl/urf_verify.sv
rtl/udp_receive_filter_unit.sv
dv/tb_udp_receive_filter_unit.sv
